### rtl/tbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

  localparam int PC_W    = 48;
  localparam int COUNT_W = 32;

  typedef logic [1:0]         ctr_t;
  typedef logic [PC_W-1:0]    pc_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Reset contents of the tables and the counter limits
  localparam ctr_t CTR_STRONG_TAKEN  = 2'd3;
  localparam ctr_t CTR_STRONG_GSHARE = 2'd0;
  localparam ctr_t CTR_MAX           = 2'd3;
  localparam ctr_t CTR_MIN           = 2'd0;

  // Two-bit saturating counter step
  function automatic ctr_t train2(input ctr_t ctr, input logic up);
    ctr_t res;
    if (up) begin
      res = (ctr == CTR_MAX) ? CTR_MAX : ctr_t'(ctr + 2'd1);
    end else begin
      res = (ctr == CTR_MIN) ? CTR_MIN : ctr_t'(ctr - 2'd1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/tbp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tbp_in_if;
  logic          valid;
  logic          ready;
  tbp_pkg::pc_t  branch_pc;
  logic          taken;

  modport source (output valid, output branch_pc, output taken, input ready);
  modport sink   (input valid, input branch_pc, input taken, output ready);
endinterface

interface tbp_out_if;
  logic            valid;
  logic            ready;
  logic            predicted_taken;
  logic            used_bimodal;
  logic            prediction_correct;
  tbp_pkg::count_t correct_total;

  modport source (output valid, output predicted_taken, output used_bimodal,
                  output prediction_correct, output correct_total, input ready);
  modport sink   (input valid, input predicted_taken, input used_bimodal,
                  input prediction_correct, input correct_total, output ready);
endinterface

`default_nettype wire

### rtl/tbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tbp_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/tbp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tbp_core #(
  parameter int TABLE_ENTRIES = 2048,
  parameter int HISTORY_BITS  = 11,
  parameter int IDX_W         = 11
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  tbp_in_if.sink               in_ch,
  tbp_out_if.source            out_ch,
  // bimodal + chooser memory, data is {chooser, bimodal}
  output logic                 bc_we,
  output logic [IDX_W-1:0]     bc_waddr,
  output logic [3:0]           bc_wdata,
  output logic                 bc_re,
  output logic [IDX_W-1:0]     bc_raddr,
  input  wire logic [3:0]      bc_rdata,
  // gshare memory
  output logic                 gs_we,
  output logic [IDX_W-1:0]     gs_waddr,
  output logic [1:0]           gs_wdata,
  output logic                 gs_re,
  output logic [IDX_W-1:0]     gs_raddr,
  input  wire logic [1:0]      gs_rdata
);

  localparam int XW = (HISTORY_BITS > IDX_W) ? HISTORY_BITS : IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        clr_idx_r, clr_idx_nxt;
  logic [HISTORY_BITS-1:0] hist_r, hist_nxt;
  tbp_pkg::count_t         hit_r, hit_nxt;
  logic [IDX_W-1:0]        bidx_r, gidx_r;
  logic                    taken_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_pred_r, out_used_b_r, out_ok_r;

  logic             accept;
  logic [IDX_W-1:0] in_bidx, in_gidx;
  logic [XW-1:0]    mix;
  tbp_pkg::ctr_t    bval, gval, sel;
  logic             bpred, gpred, bok, gok, use_b, pred, ok;
  logic             out_free, finish;
  tbp_pkg::ctr_t    sel_new;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Table index is the low PC bits; gshare folds in the history
  assign in_bidx = in_ch.branch_pc[IDX_W-1:0];
  assign mix     = XW'(hist_r) ^ XW'(in_bidx);
  assign in_gidx = mix[IDX_W-1:0];

  assign bc_re    = accept;
  assign bc_raddr = in_bidx;
  assign gs_re    = accept;
  assign gs_raddr = in_gidx;

  assign bval  = bc_rdata[1:0];
  assign sel   = bc_rdata[3:2];
  assign gval  = gs_rdata;
  assign bpred = bval[1];
  assign gpred = gval[1];
  assign bok   = (bpred == taken_r);
  assign gok   = (gpred == taken_r);
  assign use_b = sel[1];
  assign pred  = use_b ? bpred : gpred;
  assign ok    = (pred == taken_r);

  always_comb begin
    if (bok && !gok) begin
      sel_new = tbp_pkg::train2(sel, 1'b1);
    end else if (gok && !bok) begin
      sel_new = tbp_pkg::train2(sel, 1'b0);
    end else begin
      sel_new = sel;
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign finish   = (state_r == ST_BUSY) && out_free;

  always_comb begin
    bc_we    = 1'b0;
    bc_waddr = bidx_r;
    bc_wdata = {sel_new, tbp_pkg::train2(bval, taken_r)};
    gs_we    = 1'b0;
    gs_waddr = gidx_r;
    gs_wdata = tbp_pkg::train2(gval, taken_r);
    if (state_r == ST_CLEAR) begin
      bc_we    = 1'b1;
      bc_waddr = clr_idx_r;
      bc_wdata = {tbp_pkg::CTR_STRONG_GSHARE, tbp_pkg::CTR_STRONG_TAKEN};
      gs_we    = 1'b1;
      gs_waddr = clr_idx_r;
      gs_wdata = tbp_pkg::CTR_STRONG_TAKEN;
    end else if (finish) begin
      bc_we = 1'b1;
      gs_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    hist_nxt      = hist_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // hold the read data until the result slot frees up
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          hist_nxt      = HISTORY_BITS'({hist_r, taken_r});
          if (ok && (hit_r != '1)) begin
            hit_nxt = hit_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      hist_r      <= '0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      hist_r      <= hist_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bidx_r  <= in_bidx;
      gidx_r  <= in_gidx;
      taken_r <= in_ch.taken;
    end
    if (finish) begin
      out_pred_r   <= pred;
      out_used_b_r <= use_b;
      out_ok_r     <= ok;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.predicted_taken    = out_pred_r;
  assign out_ch.used_bimodal       = out_used_b_r;
  assign out_ch.prediction_correct = out_ok_r;
  assign out_ch.correct_total      = hit_r;

endmodule

`default_nettype wire

### rtl/tournament_branch_predictor_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Tournament branch predictor: bimodal and gshare tables with a per-PC chooser.
// in_ch carries one resolved branch per transaction (branch_pc, taken); out_ch
// returns one result per branch: the prediction made before training, which
// component was used, whether it was right and the saturating correct count.
// Both channels complete a transaction when valid and ready are high together.
// A result is registered: it is valid once its branch has been read and trained.
// One branch is handled at a time, paced by the read-modify-write of the table
// memories (a read, then training and write-back, before the next is accepted).
// The output register lets a new branch be accepted while a result waits; the
// next branch then holds in its write-back cycle until out_ch takes the result.
// After reset, a clearing pass over all TABLE_ENTRIES entries sets the bimodal and
// gshare counters to strongly taken and the chooser to strongly gshare; in_ch
// ready stays low during it. History and the correct count reset to zero.
// TABLE_ENTRIES must be a power of two; HISTORY_BITS may exceed its index width.
module tournament_branch_predictor_top #(
  parameter int TABLE_ENTRIES = 2048,
  parameter int HISTORY_BITS  = 11
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tbp_in_if.sink    in_ch,
  tbp_out_if.source out_ch
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic             bc_we, bc_re, gs_we, gs_re;
  logic [IDX_W-1:0] bc_waddr, bc_raddr, gs_waddr, gs_raddr;
  logic [3:0]       bc_wdata, bc_rdata;
  logic [1:0]       gs_wdata, gs_rdata;

  tbp_core #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .HISTORY_BITS  (HISTORY_BITS),
    .IDX_W         (IDX_W)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .bc_we    (bc_we),
    .bc_waddr (bc_waddr),
    .bc_wdata (bc_wdata),
    .bc_re    (bc_re),
    .bc_raddr (bc_raddr),
    .bc_rdata (bc_rdata),
    .gs_we    (gs_we),
    .gs_waddr (gs_waddr),
    .gs_wdata (gs_wdata),
    .gs_re    (gs_re),
    .gs_raddr (gs_raddr),
    .gs_rdata (gs_rdata)
  );

  tbp_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W),
    .DW    (4)
  ) u_bc_ram (
    .clk   (clk),
    .we    (bc_we),
    .waddr (bc_waddr),
    .wdata (bc_wdata),
    .re    (bc_re),
    .raddr (bc_raddr),
    .rdata (bc_rdata)
  );

  tbp_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W),
    .DW    (2)
  ) u_gs_ram (
    .clk   (clk),
    .we    (gs_we),
    .waddr (gs_waddr),
    .wdata (gs_wdata),
    .re    (gs_re),
    .raddr (gs_raddr),
    .rdata (gs_rdata)
  );

  // one branch in flight: ready drops right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a branch is in flight");

  // a result only appears out of the write-back cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised without a branch being trained");

  // reset starts the clearing pass with no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !in_ch.ready)
    else $error("block not in clearing pass after reset");

endmodule

`default_nettype wire

### verif/tournament_branch_predictor_top_test.sv
`timescale 1ns / 1ps

module tournament_branch_predictor_top_test;

  localparam int TABLE_ENTRIES = 2048;
  localparam int HISTORY_BITS  = 11;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int HOLD_CYCLES   = 300;
  localparam int POOL_N        = 16;

  typedef enum int {
    PH_DIRECTED, PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH, PH_PRESSURE
  } phase_t;

  typedef struct packed {
    tbp_pkg::pc_t pc;
    logic         tk;
  } branch_t;

  typedef struct packed {
    logic            predicted_taken;
    logic            used_bimodal;
    logic            prediction_correct;
    tbp_pkg::count_t correct_total;
  } verdict_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tbp_in_if  in_bus ();
  tbp_out_if out_bus ();

  tournament_branch_predictor_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .HISTORY_BITS (HISTORY_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow predictor state
  tbp_pkg::ctr_t     bim_tbl [TABLE_ENTRIES];
  tbp_pkg::ctr_t     gsh_tbl [TABLE_ENTRIES];
  tbp_pkg::ctr_t     sel_tbl [TABLE_ENTRIES];
  logic [HISTORY_BITS-1:0] hist_r;
  tbp_pkg::count_t   hits_r;

  branch_t  branch_q[$];
  verdict_t verdict_q[$];
  int       queued_n   = 0;
  int       accepted_n = 0;
  int       err_n      = 0;
  logic     in_took    = 1'b0;

  phase_t phase         = PH_DIRECTED;
  int     src_idle_pct  = 0;
  int     snk_stall_pct = 0;
  int     hold_left     = 0;
  logic   hold_done     = 1'b0;

  // Recurring branches so the tables actually train
  tbp_pkg::pc_t hot_pc   [POOL_N];
  int           hot_mode [POOL_N];
  int           hot_len  [POOL_N];
  int           hot_iter [POOL_N];

  function automatic tbp_pkg::ctr_t sat_step(input tbp_pkg::ctr_t c, input logic up);
    if (up) return (&c) ? c : tbp_pkg::ctr_t'(c + 2'd1);
    return (|c) ? tbp_pkg::ctr_t'(c - 2'd1) : c;
  endfunction

  function automatic verdict_t resolve_branch(input tbp_pkg::pc_t pc, input logic tk);
    logic [IDX_W-1:0] bidx;
    logic [IDX_W-1:0] gidx;
    tbp_pkg::ctr_t    bval;
    tbp_pkg::ctr_t    gval;
    tbp_pkg::ctr_t    sval;
    logic             bhit;
    logic             ghit;
    logic             guess;
    verdict_t         v;
    bidx  = pc[IDX_W-1:0];
    // truncation of the wider xor is the modulo over the table size
    gidx  = IDX_W'(hist_r ^ bidx);
    bval  = bim_tbl[bidx];
    gval  = gsh_tbl[gidx];
    sval  = sel_tbl[bidx];
    bhit  = (bval[1] == tk);
    ghit  = (gval[1] == tk);
    guess = sval[1] ? bval[1] : gval[1];
    if (guess == tk && hits_r != '1) hits_r = hits_r + 1;
    bim_tbl[bidx] = sat_step(bval, tk);
    gsh_tbl[gidx] = sat_step(gval, tk);
    // move the chooser only when exactly one component was right
    if (bhit != ghit) sel_tbl[bidx] = sat_step(sval, bhit);
    hist_r = HISTORY_BITS'({hist_r, tk});
    v.predicted_taken    = guess;
    v.used_bimodal       = sval[1];
    v.prediction_correct = (guess == tk);
    v.correct_total      = hits_r;
    return v;
  endfunction

  task automatic push_branch(input tbp_pkg::pc_t pc, input logic tk);
    branch_t b;
    b.pc = pc;
    b.tk = tk;
    branch_q.push_back(b);
    queued_n++;
  endtask

  function automatic tbp_pkg::pc_t rand_pc();
    return tbp_pkg::pc_t'({$urandom(), $urandom()});
  endfunction

  task automatic refresh_pool();
    for (int k = 0; k < POOL_N; k++) begin
      hot_pc[k] = rand_pc();
      // the last few alias earlier entries: same index, different upper bits
      if (k >= POOL_N - 4)
        hot_pc[k][IDX_W-1:0] = hot_pc[k - (POOL_N - 4)][IDX_W-1:0];
      hot_mode[k] = $urandom_range(3);
      hot_len[k]  = $urandom_range(8, 2);
      hot_iter[k] = 0;
    end
  endtask

  task automatic queue_random(input int n);
    int   k;
    logic tk;
    refresh_pool();
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(99) < 75) begin
        k = $urandom_range(POOL_N - 1);
        case (hot_mode[k])
          0:       tk = ($urandom_range(9) != 0);
          1:       tk = ($urandom_range(9) == 0);
          2:       tk = hot_iter[k][0];
          default: tk = ((hot_iter[k] % hot_len[k]) != hot_len[k] - 1);
        endcase
        hot_iter[k]++;
        push_branch(hot_pc[k], tk);
      end else begin
        push_branch(rand_pc(), $urandom_range(1));
      end
    end
  endtask

  task automatic queue_directed();
    push_branch('0, 1'b1);
    push_branch('0, 1'b1);
    repeat (3) push_branch('1, 1'b0);
    push_branch(tbp_pkg::pc_t'(1) << (tbp_pkg::PC_W - 1), 1'b0);
    push_branch('0, 1'b0);
    push_branch('0, 1'b0);
    push_branch(48'h5555_5555_5555, 1'b1);
    push_branch(48'hAAAA_AAAA_AAAA, 1'b0);
    for (int j = 0; j < 6; j++) push_branch(48'h123, j[0] == 1'b0);
    push_branch(48'h7FF, 1'b1);
    push_branch(48'h800, 1'b0);
    repeat (3) push_branch('0, 1'b1);
  endtask

  task automatic wait_drained();
    while (accepted_n != queued_n || verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic cmp_field(input string name, input longint unsigned want,
                           input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      err_n++;
    end
  endtask

  // Branch driver: hold an offered transaction until it is taken
  always @(negedge clk) begin : drive_branches
    branch_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !in_took) begin
      in_bus.valid <= 1'b1;
    end else if (branch_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
      nxt = branch_q.pop_front();
      in_bus.valid     <= 1'b1;
      in_bus.branch_pc <= nxt.pc;
      in_bus.taken     <= nxt.tk;
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_bus.ready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
  end

  // Long receiver hold-off so the block backs up into its input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (phase == PH_PRESSURE && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_channels
    verdict_t want;
    in_took <= in_bus.valid && in_bus.ready;
    if (in_bus.valid && in_bus.ready) begin
      verdict_q.push_back(resolve_branch(in_bus.branch_pc, in_bus.taken));
      accepted_n++;
    end
    if (out_bus.valid && out_bus.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got pred=%0b bim=%0b ok=%0b total=%0d",
                 $time, out_bus.predicted_taken, out_bus.used_bimodal,
                 out_bus.prediction_correct, out_bus.correct_total);
        err_n++;
      end else begin
        want = verdict_q.pop_front();
        cmp_field("predicted_taken", want.predicted_taken, out_bus.predicted_taken);
        cmp_field("used_bimodal", want.used_bimodal, out_bus.used_bimodal);
        cmp_field("prediction_correct", want.prediction_correct,
                  out_bus.prediction_correct);
        cmp_field("correct_total", want.correct_total, out_bus.correct_total);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL tournament_branch_predictor_top");
    $finish;
  end

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.branch_pc = '0;
    in_bus.taken     = 1'b0;
    out_bus.ready    = 1'b0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      bim_tbl[k] = tbp_pkg::CTR_STRONG_TAKEN;
      gsh_tbl[k] = tbp_pkg::CTR_STRONG_TAKEN;
      sel_tbl[k] = tbp_pkg::CTR_STRONG_GSHARE;
    end
    hist_r = '0;
    hits_r = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    queue_directed();
    wait_drained();

    phase = PH_FREE;
    queue_random(330);
    wait_drained();

    phase        = PH_SRC_IDLE;
    src_idle_pct = 56;
    queue_random(330);
    wait_drained();

    phase         = PH_SNK_STALL;
    src_idle_pct  = 0;
    snk_stall_pct = 56;
    queue_random(330);
    wait_drained();

    phase         = PH_BOTH;
    src_idle_pct  = 25;
    snk_stall_pct = 25;
    queue_random(330);
    wait_drained();

    phase         = PH_PRESSURE;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    queue_random(300);
    wait_drained();

    repeat (20) @(negedge clk);
    if (err_n == 0) begin
      $display("PASS tournament_branch_predictor_top");
    end else begin
      $display("FAIL tournament_branch_predictor_top");
    end
    $finish;
  end

endmodule
